>>> sv/assert_macros.svh
// Assertion macros shared by the context table RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> sv/hctl_pkg.sv
// Package for the flow context table: field widths, codes and shared types.
// Used by the interfaces, the scan controller and the top level.
package hctl_pkg;

    localparam int PROFILE_W = 16;
    localparam int KEY_W     = 64;
    localparam int STAMP_W   = 32;
    localparam int CID_W     = 4;
    localparam int OUTCOME_W = 2;

    localparam logic [CID_W-1:0]     MAX_CID_RESET  = 4'd15;
    localparam logic [PROFILE_W-1:0] PROFILE_UNCOMP = 16'd0;

    // Result codes returned with each context identifier.
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT     = 2'd0,
        OUT_NEW     = 2'd1,
        OUT_REPLACE = 2'd2,
        OUT_UNCOMP  = 2'd3
    } outcome_t;

    // Lookup sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } ctrl_state_t;

    // One stored context as kept in the context RAM.
    typedef struct packed {
        logic [PROFILE_W-1:0] profile;
        logic [KEY_W-1:0]     key;
        logic [STAMP_W-1:0]   stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic             valid;
        logic [CID_W-1:0] cid;
        outcome_t         outcome;
    } res_t;

endpackage

>>> sv/hctl_if.sv
// Channel interfaces of the flow context table: lookup requests, results
// and the configuration write channel. Depends on hctl_pkg.
interface hctl_req_if import hctl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PROFILE_W-1:0] profile_id;
    logic [KEY_W-1:0]     flow_key;
    logic [STAMP_W-1:0]   now_ms;

    modport source (output valid, output profile_id, output flow_key, output now_ms,
                    input ready);
    modport sink   (input valid, input profile_id, input flow_key, input now_ms,
                    output ready);
endinterface

interface hctl_rsp_if import hctl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CID_W-1:0]     cid;
    logic [OUTCOME_W-1:0] outcome;

    modport source (output valid, output cid, output outcome, input ready);
    modport sink   (input valid, input cid, input outcome, output ready);
endinterface

interface hctl_cfg_if import hctl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CID_W-1:0] max_cid;

    modport source (output valid, output max_cid, input ready);
    modport sink   (input valid, input max_cid, output ready);
endinterface

>>> sv/hctl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hctl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/hctl_scan.sv
// Lookup sequencer: for a compressed profile it scans the context RAM one entry per cycle
// for a hit, the lowest free slot and the oldest stamp, then writes the chosen entry back.
// Depends on hctl_pkg, hctl_if and assert_macros.svh.
`include "assert_macros.svh"

module hctl_scan import hctl_pkg::*; #(
    parameter int CONTEXTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    hctl_req_if.sink                    req,
    input  logic [CID_W-1:0]            max_cid,
    output res_t                        res,
    input  logic                        res_ready,
    output logic                        ram_we,
    output logic [$clog2(CONTEXTS)-1:0] ram_waddr,
    output logic [ENTRY_W-1:0]          ram_wdata,
    output logic [$clog2(CONTEXTS)-1:0] ram_raddr,
    input  logic [ENTRY_W-1:0]          ram_rdata
);

    localparam int AW = $clog2(CONTEXTS);
    localparam int CID_TOP = (1 << CID_W) - 1;
    localparam logic [CID_W-1:0] LIM_MAX =
        (CONTEXTS - 1 < CID_TOP) ? CID_W'(CONTEXTS - 1) : CID_W'(CID_TOP);
    localparam logic [CID_W-1:0] CID_ONE = CID_W'(1);

    ctrl_state_t state_reg, state_next;

    logic [CONTEXTS-1:0]  valid_reg, valid_next;
    logic [PROFILE_W-1:0] prof_reg, prof_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [STAMP_W-1:0]   now_reg, now_next;
    logic [CID_W-1:0]     lim_reg, lim_next;
    logic [CID_W-1:0]     idx_reg, idx_next;
    logic                 hit_found_reg, hit_found_next;
    logic [CID_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [CID_W-1:0]     free_idx_reg, free_idx_next;
    logic [CID_W-1:0]     old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0]   old_stamp_reg, old_stamp_next;
    logic [CID_W-1:0]     res_cid_reg, res_cid_next;
    outcome_t             res_outcome_reg, res_outcome_next;

    entry_t           ent;
    logic             ent_valid;
    logic             ent_match;
    logic             req_accept;
    logic [CID_W-1:0] lim_calc;
    logic [CID_W-1:0] chosen;
    outcome_t         chosen_outcome;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;

    // Effective limit: max_cid clamped into 1..LIM_MAX, the lesser of CONTEXTS-1 and the largest context id.
    always_comb
    begin
        if (max_cid == '0)
        begin
            lim_calc = CID_ONE;
        end
        else if (max_cid > LIM_MAX)
        begin
            lim_calc = LIM_MAX;
        end
        else
        begin
            lim_calc = max_cid;
        end
    end

    // Entry under comparison: RAM data returned for idx_reg.
    assign ent       = entry_t'(ram_rdata);
    assign ent_valid = valid_reg[AW'(idx_reg)];
    assign ent_match = ent_valid && (ent.profile == prof_reg) && (ent.key == key_reg);

    // Final choice: hit first, then lowest free slot, then oldest entry.
    always_comb
    begin
        priority if (hit_found_reg)
        begin
            chosen         = hit_idx_reg;
            chosen_outcome = OUT_HIT;
        end
        else if (free_found_reg)
        begin
            chosen         = free_idx_reg;
            chosen_outcome = OUT_NEW;
        end
        else
        begin
            chosen         = old_idx_reg;
            chosen_outcome = OUT_REPLACE;
        end
    end

    // Next state, scan bookkeeping and RAM access.
    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        prof_next        = prof_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        lim_next         = lim_reg;
        idx_next         = idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        old_idx_next     = old_idx_reg;
        old_stamp_next   = old_stamp_reg;
        res_cid_next     = res_cid_reg;
        res_outcome_next = res_outcome_reg;
        ram_we           = 1'b0;
        ram_waddr        = AW'(chosen);
        ram_wdata        = {prof_reg, key_reg, now_reg};
        ram_raddr        = AW'(idx_reg + CID_ONE);
        res.valid        = 1'b0;
        res.cid          = res_cid_reg;
        res.outcome      = res_outcome_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Entry 1 is read as the request is taken.
                ram_raddr = AW'(CID_ONE);
                if (req_accept)
                begin
                    if (req.profile_id == PROFILE_UNCOMP)
                    begin
                        res_cid_next     = '0;
                        res_outcome_next = OUT_UNCOMP;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        prof_next       = req.profile_id;
                        key_next        = req.flow_key;
                        now_next        = req.now_ms;
                        lim_next        = lim_calc;
                        idx_next        = CID_ONE;
                        hit_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // First match and first free slot win.
                if (ent_match && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = idx_reg;
                end
                if (!ent_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                // Strictly smaller stamp replaces, so the lowest index wins ties.
                if ((idx_reg == CID_ONE) || (ent.stamp < old_stamp_reg))
                begin
                    old_idx_next   = idx_reg;
                    old_stamp_next = ent.stamp;
                end
                if (idx_reg == lim_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + CID_ONE;
                end
            end

            ST_FINISH:
            begin
                // On a hit profile and key are unchanged, so the whole word is rewritten.
                ram_we                    = 1'b1;
                valid_next[AW'(chosen)]   = 1'b1;
                res_cid_next              = chosen;
                res_outcome_next          = chosen_outcome;
                state_next                = ST_EMIT;
            end

            ST_EMIT:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Request copy and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        prof_reg        <= prof_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
        lim_reg         <= lim_next;
        idx_reg         <= idx_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        old_idx_reg     <= old_idx_next;
        old_stamp_reg   <= old_stamp_next;
        res_cid_reg     <= res_cid_next;
        res_outcome_reg <= res_outcome_next;
    end

    // The scan never runs past the limit taken with the request.
    `ASSERT_CLK(a_scan_in_limit, (state_reg == ST_SCAN) |-> (idx_reg <= lim_reg && idx_reg != '0), "scan index outside 1..limit")

    // The entry just written back is marked valid.
    `ASSERT_CLK(a_chosen_valid, (state_reg == ST_FINISH) |=> valid_reg[AW'(res_cid_reg)], "chosen context not marked valid")

    // A compressed result names a context inside the allowed range.
    `ASSERT_CLK(a_cid_range, (state_reg == ST_EMIT && res_outcome_reg != OUT_UNCOMP) |-> (res_cid_reg != '0 && res_cid_reg <= lim_reg), "context id outside 1..limit")

endmodule

>>> sv/header_context_table_lru_unit.sv
// Top level of the flow context table with least-recently-used replacement.
// Depends on hctl_pkg, hctl_if, hctl_ram and hctl_scan.
//
//   channel  direction  payload                         handshake
//   req      in         profile_id, flow_key, now_ms    valid / ready
//   rsp      out        cid, outcome                    valid / ready
//   cfg      in         max_cid                         valid / ready (always ready)
//
// A compressed request is taken, entries 1..limit are read from the context
// RAM, the chosen entry is written back and the result is handed to the
// output register. An uncompressed request goes straight to the hand-over.
// Reset clears the valid bits rather than the RAM, which needs no clearing.
// A stalled result waits in the output register while the next request is
// taken; it then holds the sequencer in its final state until the slot frees.

module header_context_table_lru_unit import hctl_pkg::*; #(
    parameter int CONTEXTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    hctl_req_if.sink    req,
    hctl_rsp_if.source  rsp,
    hctl_cfg_if.sink    cfg
);

    localparam int AW = $clog2(CONTEXTS);

    logic [CID_W-1:0]   max_cid_reg;
    res_t               res;
    logic               res_ready;
    logic               out_valid_reg;
    logic [CID_W-1:0]   out_cid_reg;
    outcome_t           out_outcome_reg;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Configuration register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cid_reg <= MAX_CID_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_cid_reg <= cfg.max_cid;
        end
    end

    // Context storage: profile, key and stamp of every entry.
    hctl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CONTEXTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Lookup sequencer.
    hctl_scan #(
        .CONTEXTS (CONTEXTS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .max_cid   (max_cid_reg),
        .res       (res),
        .res_ready (res_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register decouples the sequencer from the result consumer.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_cid_reg     <= res.cid;
            out_outcome_reg <= res.outcome;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.cid     = out_cid_reg;
    assign rsp.outcome = OUTCOME_W'(out_outcome_reg);

endmodule
